// ===== rtl/core/ipsc_pkg.sv =====
// Package with beat types, prefix constants and match functions for the address classifier.
package ipsc_pkg;

    // Input beat: address family and the 128-bit address split in two words.
    typedef struct packed {
        logic        is_ipv6;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } ipsc_in_t;

    // Result beat: the two classification flags.
    typedef struct packed {
        logic is_public;
        logic is_forbidden;
    } ipsc_out_t;

    // Classification of one address before the flags are formed.
    typedef struct packed {
        logic forb;
        logic loc;
    } ipsc_class_t;

    // IPv4 masks by prefix length.
    localparam logic [31:0] V4_MASK_32 = 32'hFFFF_FFFF;
    localparam logic [31:0] V4_MASK_24 = 32'hFFFF_FF00;
    localparam logic [31:0] V4_MASK_16 = 32'hFFFF_0000;
    localparam logic [31:0] V4_MASK_15 = 32'hFFFE_0000;
    localparam logic [31:0] V4_MASK_12 = 32'hFFF0_0000;
    localparam logic [31:0] V4_MASK_10 = 32'hFFC0_0000;
    localparam logic [31:0] V4_MASK_8  = 32'hFF00_0000;
    localparam logic [31:0] V4_MASK_4  = 32'hF000_0000;

    // IPv4 networks that must never be contacted.
    localparam logic [31:0] V4_BCAST     = 32'hFFFF_FFFF;
    localparam logic [31:0] V4_PROTO     = 32'hC000_0000;
    localparam logic [31:0] V4_TEST_NET1 = 32'hC000_0200;
    localparam logic [31:0] V4_AS112_A   = 32'hC01F_C400;
    localparam logic [31:0] V4_AMT       = 32'hC034_C100;
    localparam logic [31:0] V4_RELAY6TO4 = 32'hC058_6300;
    localparam logic [31:0] V4_AS112_B   = 32'hC0AF_3000;
    localparam logic [31:0] V4_TEST_NET2 = 32'hC633_6400;
    localparam logic [31:0] V4_TEST_NET3 = 32'hCB00_7100;
    localparam logic [31:0] V4_BENCH     = 32'hC612_0000;
    localparam logic [31:0] V4_THIS_NET  = 32'h0000_0000;
    localparam logic [31:0] V4_LOOPBACK  = 32'h7F00_0000;
    localparam logic [31:0] V4_MCAST     = 32'hE000_0000;
    localparam logic [31:0] V4_RESERVED  = 32'hF000_0000;

    // IPv4 networks that are local only.
    localparam logic [31:0] V4_LINK_LOCAL = 32'hA9FE_0000;
    localparam logic [31:0] V4_PRIV_172   = 32'hAC10_0000;
    localparam logic [31:0] V4_PRIV_192   = 32'hC0A8_0000;
    localparam logic [31:0] V4_SHARED     = 32'h6440_0000;
    localparam logic [31:0] V4_PRIV_10    = 32'h0A00_0000;

    // IPv6 upper-word networks and masks.
    localparam logic [63:0] V6_MASK_64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] V6_MASK_48 = 64'hFFFF_FFFF_FFFF_0000;
    localparam logic [63:0] V6_MASK_32 = 64'hFFFF_FFFF_0000_0000;
    localparam logic [63:0] V6_MASK_23 = 64'hFFFF_FE00_0000_0000;
    localparam logic [63:0] V6_MASK_10 = 64'hFFC0_0000_0000_0000;
    localparam logic [63:0] V6_MASK_8  = 64'hFF00_0000_0000_0000;
    localparam logic [63:0] V6_MASK_7  = 64'hFE00_0000_0000_0000;

    localparam logic [63:0] V6_MCAST      = 64'hFF00_0000_0000_0000;
    localparam logic [63:0] V6_IETF       = 64'h2001_0000_0000_0000;
    localparam logic [63:0] V6_DISCARD    = 64'h0100_0000_0000_0000;
    localparam logic [63:0] V6_DOC        = 64'h2001_0DB8_0000_0000;
    localparam logic [63:0] V6_AS112      = 64'h2620_004F_8000_0000;
    localparam logic [63:0] V6_LINK_LOCAL = 64'hFE80_0000_0000_0000;
    localparam logic [63:0] V6_SITE_LOCAL = 64'hFEC0_0000_0000_0000;
    localparam logic [63:0] V6_UNIQUE     = 64'hFC00_0000_0000_0000;
    localparam logic [63:0] V6_NAT64      = 64'h0064_FF9B_0000_0000;
    localparam logic [31:0] V6_MAPPED_MID = 32'h0000_FFFF;

    // True when the address lies in the network under the mask.
    function automatic logic pfx4(input logic [31:0] a, input logic [31:0] net,
                                  input logic [31:0] mask);
        return (a & mask) == net;
    endfunction

    function automatic logic pfx6hi(input logic [63:0] hi, input logic [63:0] net,
                                    input logic [63:0] mask);
        return (hi & mask) == net;
    endfunction

    function automatic logic v4_forbidden(input logic [31:0] a);
        return pfx4(a, V4_BCAST, V4_MASK_32)     || pfx4(a, V4_PROTO, V4_MASK_24)     ||
               pfx4(a, V4_TEST_NET1, V4_MASK_24) || pfx4(a, V4_AS112_A, V4_MASK_24)   ||
               pfx4(a, V4_AMT, V4_MASK_24)       || pfx4(a, V4_RELAY6TO4, V4_MASK_24) ||
               pfx4(a, V4_AS112_B, V4_MASK_24)   || pfx4(a, V4_TEST_NET2, V4_MASK_24) ||
               pfx4(a, V4_TEST_NET3, V4_MASK_24) || pfx4(a, V4_BENCH, V4_MASK_15)     ||
               pfx4(a, V4_THIS_NET, V4_MASK_8)   || pfx4(a, V4_LOOPBACK, V4_MASK_8)   ||
               pfx4(a, V4_MCAST, V4_MASK_4)      || pfx4(a, V4_RESERVED, V4_MASK_4);
    endfunction

    function automatic logic v4_local(input logic [31:0] a);
        return pfx4(a, V4_LINK_LOCAL, V4_MASK_16) || pfx4(a, V4_PRIV_172, V4_MASK_12) ||
               pfx4(a, V4_PRIV_192, V4_MASK_16)   || pfx4(a, V4_SHARED, V4_MASK_10)   ||
               pfx4(a, V4_PRIV_10, V4_MASK_8);
    endfunction

    // Full classification of one input beat.
    function automatic ipsc_class_t classify(input ipsc_in_t d);
        logic [31:0] a;
        logic        hi_zero;
        logic        v6_forb;
        logic        v6_loc;
        logic        embed;
        ipsc_class_t c;
        a       = d.addr_low[31:0];
        hi_zero = (d.addr_high == 64'd0);
        // The whole ::/96 block (unspecified, loopback, v4-compatible) is forbidden.
        v6_forb = (hi_zero && d.addr_low[63:32] == 32'd0) ||
                  pfx6hi(d.addr_high, V6_MCAST, V6_MASK_8)    ||
                  pfx6hi(d.addr_high, V6_IETF, V6_MASK_23)    ||
                  pfx6hi(d.addr_high, V6_DISCARD, V6_MASK_64) ||
                  pfx6hi(d.addr_high, V6_DOC, V6_MASK_32)     ||
                  pfx6hi(d.addr_high, V6_AS112, V6_MASK_48);
        v6_loc  = pfx6hi(d.addr_high, V6_LINK_LOCAL, V6_MASK_10) ||
                  pfx6hi(d.addr_high, V6_SITE_LOCAL, V6_MASK_10) ||
                  pfx6hi(d.addr_high, V6_UNIQUE, V6_MASK_7);
        // Mapped and NAT64 forms carry an IPv4 word in the low 32 bits.
        embed   = (hi_zero && d.addr_low[63:32] == V6_MAPPED_MID) ||
                  (d.addr_high == V6_NAT64 && d.addr_low[63:32] == 32'd0);
        if (!d.is_ipv6 || (!v6_forb && !v6_loc && embed)) begin
            c.forb = v4_forbidden(a);
            c.loc  = v4_local(a);
        end else begin
            c.forb = v6_forb;
            c.loc  = !v6_forb && v6_loc;
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/ip_address_scope_classifier.sv =====
// Top level of the IPv4/IPv6 special-purpose address classifier.
// Path of an accepted input beat: input register, prefix compares, result register, then m_.
// Throughput: one beat per cycle while m_ready is high.
// A stalled result register still lets one more beat into the input register.
// Reset (aresetn low, synchronous) empties both stages; payload registers are not reset.
module ip_address_scope_classifier (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ipsc_pkg::ipsc_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ipsc_pkg::ipsc_out_t m_data
);
    import ipsc_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    ipsc_in_t    in_data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    ipsc_out_t   out_data_reg;
    ipsc_out_t   out_data_next;
    ipsc_class_t cls;
    logic        out_ready;

    // Stage handshakes: each stage takes a beat when it is empty or is being drained.
    assign out_ready = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || out_ready;

    // Classification between the two registers.
    always_comb begin
        cls                        = classify(in_data_reg);
        out_data_next.is_forbidden = cls.forb;
        out_data_next.is_public    = !(cls.forb || cls.loc);
    end

    // Next valid flags for both stages.
    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        if (out_ready) begin
            out_valid_next = in_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (out_ready && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // A forbidden address is never reported as public.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.is_public && m_data.is_forbidden))
        else $error("result beat is both public and forbidden");

    // A beat that leaves the input stage shows up at the result port next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_ready) |=> m_valid)
        else $error("beat lost between input and result stage");

    // Input back-pressure only when both stages hold a beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled with a free stage");

endmodule

// ===== bench/ip_address_scope_classifier_tb.sv =====
// Testbench for the address scope classifier: directed and random address beats with a scoreboard.
`timescale 1ns / 1ps

module ip_address_scope_classifier_tb;
    import ipsc_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    ipsc_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    ipsc_out_t m_data;

    ipsc_out_t   flags_due_q[$];
    ipsc_out_t   flags_due;
    int          error_count = 0;
    int          idle_cycles = 0;
    int unsigned ready_left  = 0;
    bit          gaps_off    = 1'b0;

    ip_address_scope_classifier u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // Address matching helpers for the flag predictor.
    function automatic bit in_net4(logic [31:0] a, logic [31:0] net, int unsigned len);
        logic [31:0] mask;
        mask = (len == 0) ? 32'd0 : (~32'd0 << (32 - len));
        return (a & mask) == net;
    endfunction

    function automatic bit in_net6(logic [127:0] a, logic [127:0] net, int unsigned len);
        logic [127:0] mask;
        mask = (len == 0) ? 128'd0 : (~128'd0 << (128 - len));
        return (a & mask) == net;
    endfunction

    // IPv4 networks that must never be contacted.
    function automatic bit v4_no_contact(logic [31:0] a);
        return in_net4(a, 32'hFFFF_FFFF, 32) || in_net4(a, 32'hC000_0000, 24) ||
               in_net4(a, 32'hC000_0200, 24) || in_net4(a, 32'hC01F_C400, 24) ||
               in_net4(a, 32'hC034_C100, 24) || in_net4(a, 32'hC058_6300, 24) ||
               in_net4(a, 32'hC0AF_3000, 24) || in_net4(a, 32'hC633_6400, 24) ||
               in_net4(a, 32'hCB00_7100, 24) || in_net4(a, 32'hC612_0000, 15) ||
               in_net4(a, 32'h0000_0000, 8)  || in_net4(a, 32'h7F00_0000, 8)  ||
               in_net4(a, 32'hE000_0000, 4)  || in_net4(a, 32'hF000_0000, 4);
    endfunction

    // IPv4 networks that are private, shared or link-local.
    function automatic bit v4_private(logic [31:0] a);
        return in_net4(a, 32'hA9FE_0000, 16) || in_net4(a, 32'hAC10_0000, 12) ||
               in_net4(a, 32'hC0A8_0000, 16) || in_net4(a, 32'h6440_0000, 10) ||
               in_net4(a, 32'h0A00_0000, 8);
    endfunction

    // IPv6 networks that must never be contacted; ::/96 covers ::, ::1 and v4-compatible.
    function automatic bit v6_no_contact(logic [127:0] a);
        return in_net6(a, 128'd0, 96) ||
               in_net6(a, {64'hFF00_0000_0000_0000, 64'd0}, 8)  ||
               in_net6(a, {64'h2001_0000_0000_0000, 64'd0}, 23) ||
               in_net6(a, {64'h0100_0000_0000_0000, 64'd0}, 64) ||
               in_net6(a, {64'h2001_0DB8_0000_0000, 64'd0}, 32) ||
               in_net6(a, {64'h2620_004F_8000_0000, 64'd0}, 48);
    endfunction

    function automatic bit v6_private(logic [127:0] a);
        return in_net6(a, {64'hFE80_0000_0000_0000, 64'd0}, 10) ||
               in_net6(a, {64'hFEC0_0000_0000_0000, 64'd0}, 10) ||
               in_net6(a, {64'hFC00_0000_0000_0000, 64'd0}, 7);
    endfunction

    // Expected flags for one input beat.
    function automatic ipsc_out_t predict_scope(ipsc_in_t beat);
        logic [127:0] a;
        logic [31:0]  w;
        bit           forb;
        bit           priv;
        ipsc_out_t    flags;
        a = {beat.addr_high, beat.addr_low};
        w = beat.addr_low[31:0];
        if (!beat.is_ipv6) begin
            forb = v4_no_contact(w);
            priv = v4_private(w);
        end else if (v6_no_contact(a)) begin
            forb = 1'b1;
            priv = 1'b0;
        end else if (v6_private(a)) begin
            forb = 1'b0;
            priv = 1'b1;
        end else if (in_net6(a, {64'd0, 64'h0000_FFFF_0000_0000}, 96) ||
                     in_net6(a, {64'h0064_FF9B_0000_0000, 64'd0}, 96)) begin
            // Mapped and NAT64 forms are judged by their embedded IPv4 word.
            forb = v4_no_contact(w);
            priv = v4_private(w);
        end else begin
            forb = 1'b0;
            priv = 1'b0;
        end
        flags.is_public    = !(forb || priv);
        flags.is_forbidden = forb;
        return flags;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (gaps_off || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic ipsc_in_t make_beat(bit v6, logic [63:0] hi, logic [63:0] lo);
        ipsc_in_t beat;
        beat.is_ipv6   = v6;
        beat.addr_high = hi;
        beat.addr_low  = lo;
        return beat;
    endfunction

    // IPv4 word, often inside or just outside one of the special networks.
    function automatic logic [31:0] random_v4();
        logic [31:0] base;
        int unsigned len;
        int unsigned host;
        logic [63:0] span;
        if ($urandom_range(0, 2) == 0) return $urandom;
        case ($urandom_range(0, 18))
            0:  begin base = 32'hFFFF_FFFF; len = 32; end
            1:  begin base = 32'hC000_0000; len = 24; end
            2:  begin base = 32'hC000_0200; len = 24; end
            3:  begin base = 32'hC01F_C400; len = 24; end
            4:  begin base = 32'hC034_C100; len = 24; end
            5:  begin base = 32'hC058_6300; len = 24; end
            6:  begin base = 32'hC0AF_3000; len = 24; end
            7:  begin base = 32'hC633_6400; len = 24; end
            8:  begin base = 32'hCB00_7100; len = 24; end
            9:  begin base = 32'hC612_0000; len = 15; end
            10: begin base = 32'h0000_0000; len = 8;  end
            11: begin base = 32'h7F00_0000; len = 8;  end
            12: begin base = 32'hE000_0000; len = 4;  end
            13: begin base = 32'hF000_0000; len = 4;  end
            14: begin base = 32'hA9FE_0000; len = 16; end
            15: begin base = 32'hAC10_0000; len = 12; end
            16: begin base = 32'hC0A8_0000; len = 16; end
            17: begin base = 32'h6440_0000; len = 10; end
            default: begin base = 32'h0A00_0000; len = 8; end
        endcase
        // One extra host bit sometimes flips the last prefix bit to land just outside.
        host = 32 - len + $urandom_range(0, 1);
        span = (64'd1 << host) - 64'd1;
        return base ^ (32'($urandom) & span[31:0]);
    endfunction

    // IPv6 address near one of the special networks.
    function automatic logic [127:0] random_v6_near_net();
        logic [127:0] base;
        int unsigned  len;
        int unsigned  host;
        logic [127:0] rnd;
        logic [127:0] span;
        case ($urandom_range(0, 10))
            0: begin base = 128'd0; len = 128; end
            1: begin base = 128'd1; len = 128; end
            2: begin base = 128'd0; len = 96; end
            3: begin base = {64'hFF00_0000_0000_0000, 64'd0}; len = 8;  end
            4: begin base = {64'h2001_0000_0000_0000, 64'd0}; len = 23; end
            5: begin base = {64'h0100_0000_0000_0000, 64'd0}; len = 64; end
            6: begin base = {64'h2001_0DB8_0000_0000, 64'd0}; len = 32; end
            7: begin base = {64'h2620_004F_8000_0000, 64'd0}; len = 48; end
            8: begin base = {64'hFE80_0000_0000_0000, 64'd0}; len = 10; end
            9: begin base = {64'hFEC0_0000_0000_0000, 64'd0}; len = 10; end
            default: begin base = {64'hFC00_0000_0000_0000, 64'd0}; len = 7; end
        endcase
        host = 128 - len + $urandom_range(0, 1);
        rnd  = {$urandom, $urandom, $urandom, $urandom};
        span = (128'd1 << host) - 128'd1;
        return base ^ (rnd & span);
    endfunction

    // One random address beat of either family.
    function automatic ipsc_in_t random_beat();
        int unsigned  pick;
        logic [127:0] a;
        logic [63:0]  middle_flip;
        pick        = $urandom_range(0, 99);
        // Occasionally break the fixed middle word of an embedded form by one bit.
        middle_flip = ($urandom_range(0, 3) == 0) ? (64'd1 << $urandom_range(32, 63)) : 64'd0;
        if (pick < 45) begin
            // IPv4: the upper bits are junk that must be ignored.
            return make_beat(1'b0, {$urandom, $urandom}, {$urandom, random_v4()});
        end else if (pick < 56) begin
            return make_beat(1'b1, {$urandom, $urandom}, {$urandom, $urandom});
        end else if (pick < 75) begin
            a = random_v6_near_net();
            return make_beat(1'b1, a[127:64], a[63:0]);
        end else if (pick < 86) begin
            return make_beat(1'b1, 64'd0,
                             {32'h0000_FFFF, random_v4()} ^ middle_flip);
        end else if (pick < 96) begin
            return make_beat(1'b1, 64'h0064_FF9B_0000_0000,
                             {32'd0, random_v4()} ^ middle_flip);
        end
        // Deprecated v4-compatible form.
        return make_beat(1'b1, 64'd0, {32'd0, random_v4()});
    endfunction

    // Receiver: alternate ready and stall stretches; hold ready high while gaps are off.
    always @(posedge aclk) begin
        if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else if (gaps_off || !m_ready) begin
            m_ready    <= 1'b1;
            ready_left <= $urandom_range(0, 12);
        end else begin
            m_ready    <= 1'b0;
            ready_left <= pick_gap();
        end
    end

    // Scoreboard: record expected flags per input beat and check each result beat.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (flags_due_q.size() == 0) begin
                    $error("result beat with no input beat outstanding: %b", m_data);
                    error_count++;
                end else begin
                    flags_due = flags_due_q.pop_front();
                    if (m_data.is_public !== flags_due.is_public) begin
                        $error("is_public: expected %0b, actual %0b",
                               flags_due.is_public, m_data.is_public);
                        error_count++;
                    end
                    if (m_data.is_forbidden !== flags_due.is_forbidden) begin
                        $error("is_forbidden: expected %0b, actual %0b",
                               flags_due.is_forbidden, m_data.is_forbidden);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                flags_due_q.push_back(predict_scope(s_data));
            end
        end
    end

    // Watchdog on cycles where neither channel moves a beat.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Send one beat after a random gap; valid stays high if the next beat follows at once.
    task automatic send_beat(ipsc_in_t beat);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every expected result beat has arrived.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (flags_due_q.size() != 0) @(posedge aclk);
    endtask

    // IPv4 range edges; some beats carry junk in the upper bits that must be ignored.
    task automatic test_directed_ipv4();
        send_beat(make_beat(1'b0, '1, {32'hFFFF_FFFF, 32'h0000_0000}));
        send_beat(make_beat(1'b0, 64'd0, {32'd0, 32'hFFFF_FFFF}));
        send_beat(make_beat(1'b0, 64'd0, {32'd0, 32'hFFFF_FFFE}));
        send_beat(make_beat(1'b0, 64'd0, {32'd0, 32'h0AFF_FFFF}));
        send_beat(make_beat(1'b0, 64'd0, {32'd0, 32'hAC1F_FFFF}));
        send_beat(make_beat(1'b0, 64'd0, {32'd0, 32'hAC20_0000}));
        send_beat(make_beat(1'b0, 64'd0, {32'd0, 32'h6440_0000}));
        send_beat(make_beat(1'b0, 64'd0, {32'd0, 32'h6480_0000}));
        send_beat(make_beat(1'b0, 64'd0, {32'd0, 32'hC613_FFFF}));
        send_beat(make_beat(1'b0, 64'd0, {32'd0, 32'hC000_02FF}));
        send_beat(make_beat(1'b0, '1, {32'hFFFF_FFFF, 32'h0808_0808}));
    endtask

    // IPv6 ranges, embedded IPv4 forms and addresses just outside them.
    task automatic test_directed_ipv6();
        send_beat(make_beat(1'b1, 64'd0, 64'd0));
        send_beat(make_beat(1'b1, 64'd0, 64'd1));
        send_beat(make_beat(1'b1, 64'd0, 64'h0000_0000_FFFF_FFFF));
        send_beat(make_beat(1'b1, 64'd0, 64'h0000_FFFF_0A00_0001));
        send_beat(make_beat(1'b1, 64'd0, 64'h0000_FFFF_0808_0808));
        send_beat(make_beat(1'b1, 64'h0064_FF9B_0000_0000, 64'h0000_0000_C000_0201));
        send_beat(make_beat(1'b1, 64'h0064_FF9B_0000_0000, 64'h0000_0001_0000_0000));
        send_beat(make_beat(1'b1, '1, '1));
        send_beat(make_beat(1'b1, 64'hFEBF_FFFF_FFFF_FFFF, '1));
        send_beat(make_beat(1'b1, 64'hFE00_0000_0000_0000, 64'd0));
        send_beat(make_beat(1'b1, 64'h2001_01FF_FFFF_FFFF, '1));
        send_beat(make_beat(1'b1, 64'h2001_0DB8_0000_0000, 64'd1));
        send_beat(make_beat(1'b1, 64'h2620_004F_8000_0000, 64'd1));
        send_beat(make_beat(1'b1, 64'h0100_0000_0000_0001, 64'd0));
    endtask

    // Full rate on both sides: no input gaps and no result stalls.
    task automatic test_back_to_back();
        gaps_off = 1'b1;
        repeat (200) send_beat(random_beat());
        gaps_off = 1'b0;
    endtask

    // Short bursts, each followed by a pause until all results are back.
    task automatic test_pause_until_drained();
        repeat (6) begin
            repeat ($urandom_range(1, 12)) send_beat(random_beat());
            wait_drained();
        end
    endtask

    task automatic test_random_addresses();
        repeat (1400) send_beat(random_beat());
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_ipv4();
        test_directed_ipv6();
        test_back_to_back();
        test_pause_until_drained();
        test_random_addresses();
        wait_drained();
        repeat (8) @(posedge aclk);
        if (error_count == 0 && flags_due_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ipsc_pkg.sv
rtl/core/ip_address_scope_classifier.sv
bench/ip_address_scope_classifier_tb.sv
